// ----- hdl/variable_block_pool_allocator_macros.svh -----
// Assertion helpers for the allocator control module
`ifndef VARIABLE_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define VARIABLE_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define VBPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked out of reset
`define VBPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- hdl/vbpa_pkg.sv -----
package vbpa_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int ADDR_W     = 12;
    localparam int SIZE_W     = 13;
    localparam int NEED_W     = 14;
    localparam int WORD_SHIFT = 3;
    localparam int REPORT_W   = 15;

    localparam logic [SIZE_W-1:0]   POOL_MIN   = 13'd2;
    localparam logic [SIZE_W-1:0]   POOL_MAX   = 13'd4096;
    localparam logic [REPORT_W-1:0] REPORT_MAX = 15'h7FFF;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [14:0] request_bytes;
        logic [11:0] payload_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [11:0]         granted_offset;
        logic [REPORT_W-1:0] free_bytes;
        logic [REPORT_W-1:0] largest_free_bytes;
    } t_rsp;

    // One block header: allocated flag and size in words, header included
    typedef struct packed {
        logic              alloc;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef struct packed {
        logic       load_req;
        logic       cfg_we;
        logic       init_pool;
        logic       start_walk;
        logic       rd_pos;
        logic       rd_nxt;
        logic       ld_cur;
        logic       ld_nxt;
        logic       wr_claim;
        logic       wr_split;
        logic       wr_merge;
        logic       wr_release;
        logic       step_pos;
        logic       jump_nxt;
        logic       acc_cur;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       free_bad;
        logic       pos_end;
        logic       cur_free;
        logic       cur_alloc;
        logic       fits;
        logic       splits;
        logic       nx_in;
        logic       nxt_free;
        logic       before_target;
        logic       at_target;
        logic       out_free;
    } t_sts;

    // Pool size in use: register value held within the legal range
    function automatic logic [SIZE_W-1:0] pool_clamp(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < POOL_MIN) r = POOL_MIN;
        if (v > POOL_MAX) r = POOL_MAX;
        return r;
    endfunction

endpackage

// ----- hdl/variable_block_pool_allocator.sv -----
// Variable-size block pool allocator, first fit over an implicit header list.
// Request channel: i_in_valid / o_in_stall carrying t_req (allocate, free,
// clear). A request is taken when valid is high and stall is low; one
// request is worked on at a time.
// Result channel: o_out_valid / i_out_stall carrying t_rsp, one result per
// request. The result sits in an output register; while the receiver
// stalls it holds, and the next request may already be taken and walked.
// Configuration: i_cfg_valid / o_cfg_ready writes the pool size in words
// and re-forms the pool as one free block; ready is high only while idle.
// The time from acceptance to o_out_valid adds for each header read, each
// look at the header after a free block, a split, and an allocate or free
// walk that runs off the pool end. It covers both the request's own walk and
// the free-space report walk through the single header memory port, so it
// grows with the number of blocks in the pool.
// A new request is taken only after the previous result is in the output
// register.
// Reset: synchronous, active low; after it the pool is written in S_INIT
// as a single free block of 4096 words, then requests are taken.
module variable_block_pool_allocator
    import vbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rsp              o_out_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    vbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vbpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ----- hdl/vbpa_ctrl.sv -----
`include "variable_block_pool_allocator_macros.svh"

module vbpa_ctrl
    import vbpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_FETCH  = 4'd3;
    localparam logic [3:0] S_LOAD   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_SPLIT  = 4'd6;
    localparam logic [3:0] S_NFETCH = 4'd7;
    localparam logic [3:0] S_NLOAD  = 4'd8;
    localparam logic [3:0] S_MERGE  = 4'd9;
    localparam logic [3:0] S_RPT    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    localparam logic [1:0] M_ALLOC = 2'd0;
    localparam logic [1:0] M_FREE  = 2'd1;
    localparam logic [1:0] M_RPT   = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    t_cmd       cmd;

    // Sequence pool init, configuration writes, and one request through its walk and the closing report walk
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        cmd     = '0;
        unique case (r_state)
            S_INIT: begin
                cmd.init_pool = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    cmd.cfg_we = 1'b1;
                end else if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.action == ACT_ALLOC) begin
                    n_mode = M_ALLOC;
                    cmd.start_walk = 1'b1;
                    n_state = S_FETCH;
                end else if (i_sts.action == ACT_FREE) begin
                    if (i_sts.free_bad) begin
                        cmd.set_status = 1'b1;
                        cmd.status = ST_NOTALLOC;
                        n_state = S_RPT;
                    end else begin
                        n_mode = M_FREE;
                        cmd.start_walk = 1'b1;
                        n_state = S_FETCH;
                    end
                end else if (i_sts.action == ACT_CLEAR) begin
                    cmd.init_pool = 1'b1;
                    n_state = S_RPT;
                end else begin
                    n_state = S_RPT;
                end
            end
            S_FETCH: begin
                if (i_sts.pos_end) begin
                    if (r_mode == M_RPT) begin
                        n_state = S_OUT;
                    end else begin
                        cmd.set_status = 1'b1;
                        cmd.status = (r_mode == M_ALLOC) ? ST_NOFIT : ST_NOTALLOC;
                        n_state = S_RPT;
                    end
                end else begin
                    cmd.rd_pos = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.ld_cur = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_mode == M_FREE) begin
                    if (i_sts.before_target) begin
                        cmd.step_pos = 1'b1;
                        n_state = S_FETCH;
                    end else if (i_sts.at_target && i_sts.cur_alloc) begin
                        cmd.wr_release = 1'b1;
                        n_state = S_RPT;
                    end else begin
                        cmd.set_status = 1'b1;
                        cmd.status = ST_NOTALLOC;
                        n_state = S_RPT;
                    end
                end else if (r_mode == M_ALLOC && i_sts.cur_free && i_sts.fits) begin
                    cmd.wr_claim = 1'b1;
                    n_state = i_sts.splits ? S_SPLIT : S_RPT;
                end else if (i_sts.cur_free) begin
                    if (i_sts.nx_in) begin
                        n_state = S_NFETCH;
                    end else begin
                        cmd.acc_cur = (r_mode == M_RPT);
                        cmd.jump_nxt = 1'b1;
                        n_state = S_FETCH;
                    end
                end else begin
                    cmd.step_pos = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_SPLIT: begin
                cmd.wr_split = 1'b1;
                n_state = S_RPT;
            end
            S_NFETCH: begin
                cmd.rd_nxt = 1'b1;
                n_state = S_NLOAD;
            end
            S_NLOAD: begin
                cmd.ld_nxt = 1'b1;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (i_sts.nxt_free) begin
                    cmd.wr_merge = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    cmd.acc_cur = (r_mode == M_RPT);
                    cmd.jump_nxt = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_RPT: begin
                n_mode = M_RPT;
                cmd.start_walk = 1'b1;
                n_state = S_FETCH;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= M_RPT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

    `VBPA_ASSERT_NOW(a_out_slot, cmd.out_load, i_sts.out_free)
    `VBPA_ASSERT_NOW(a_one_write, 1'b1, $onehot0({cmd.wr_claim, cmd.wr_split, cmd.wr_merge, cmd.wr_release, cmd.init_pool, cmd.cfg_we}))
    `VBPA_ASSERT_NOW(a_read_inside, cmd.rd_pos, !i_sts.pos_end)
    `VBPA_ASSERT_NEXT(a_accept_starts, cmd.load_req, r_state == S_START)

endmodule

// ----- hdl/vbpa_dp.sv -----
module vbpa_dp
    import vbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_in_req,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_rsp              o_out_rsp,
    input  t_cmd              i_cmd,
    output t_sts              o_sts
);

    t_hdr                mem [HEAP_WORDS];
    t_hdr                r_rdata;
    t_req                r_req;
    t_hdr                r_cur;
    t_hdr                r_nxt;
    logic [SIZE_W-1:0]   r_pool_words;
    logic [SIZE_W-1:0]   r_pos;
    logic [REPORT_W-1:0] r_total;
    logic [REPORT_W-1:0] r_largest;
    logic [1:0]          r_status;
    logic [11:0]         r_granted;
    t_rsp                r_out;
    logic                r_out_valid;

    logic [SIZE_W-1:0]   pool;
    logic [15:0]         bytes_up;
    logic [NEED_W-1:0]   need;
    logic [SIZE_W-1:0]   span;
    logic [SIZE_W-1:0]   nx;
    logic [SIZE_W-1:0]   merged;
    logic [11:0]         target;
    logic [15:0]         pay;
    logic [16:0]         total_sum;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;
    t_hdr                wdata;

    // Walk arithmetic on the current header
    assign pool      = pool_clamp(r_pool_words);
    assign bytes_up  = {1'b0, r_req.request_bytes} + 16'd7;
    assign need      = {1'b0, bytes_up[15:WORD_SHIFT]} + 14'd1;
    assign span      = (r_cur.size == '0) ? 13'd1 : r_cur.size;
    assign nx        = r_pos + r_cur.size;
    assign merged    = r_cur.size + r_nxt.size;
    assign target    = r_req.payload_offset - 12'd1;
    assign pay       = {r_cur.size - 13'd1, 3'b000};
    assign total_sum = {2'b00, r_total} + {1'b0, pay};

    assign o_sts.action        = r_req.action;
    assign o_sts.free_bad      = (r_req.payload_offset == '0) || ({1'b0, target} >= pool);
    assign o_sts.pos_end       = (r_pos >= pool);
    assign o_sts.cur_free      = !r_cur.alloc && (r_cur.size != '0);
    assign o_sts.cur_alloc     = r_cur.alloc;
    assign o_sts.fits          = (need <= {1'b0, r_cur.size});
    assign o_sts.splits        = (need < {1'b0, r_cur.size});
    assign o_sts.nx_in         = (nx < pool);
    assign o_sts.nxt_free      = !r_nxt.alloc && (r_nxt.size != '0);
    assign o_sts.before_target = (r_pos < {1'b0, target});
    assign o_sts.at_target     = (r_pos == {1'b0, target});
    assign o_sts.out_free      = !r_out_valid || !i_out_stall;

    // Select the header write for this cycle
    always_comb begin
        we    = 1'b1;
        waddr = r_pos[ADDR_W-1:0];
        wdata = r_cur;
        priority if (i_cmd.cfg_we) begin
            waddr = '0;
            wdata = '{alloc: 1'b0, size: pool_clamp(i_cfg_data)};
        end else if (i_cmd.init_pool) begin
            waddr = '0;
            wdata = '{alloc: 1'b0, size: pool};
        end else if (i_cmd.wr_claim) begin
            wdata = '{alloc: 1'b1, size: need[SIZE_W-1:0]};
        end else if (i_cmd.wr_split) begin
            waddr = r_pos[ADDR_W-1:0] + need[ADDR_W-1:0];
            wdata = '{alloc: 1'b0, size: r_cur.size - need[SIZE_W-1:0]};
        end else if (i_cmd.wr_merge) begin
            wdata = '{alloc: 1'b0, size: merged};
        end else if (i_cmd.wr_release) begin
            wdata = '{alloc: 1'b0, size: r_cur.size};
        end else begin
            we = 1'b0;
        end
    end

    assign raddr = i_cmd.rd_nxt ? nx[ADDR_W-1:0] : r_pos[ADDR_W-1:0];

    // Header memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Hold the request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_req;
        end
        if (i_cmd.ld_cur) begin
            r_cur <= r_rdata;
        end else if (i_cmd.wr_merge) begin
            r_cur <= '{alloc: 1'b0, size: merged};
        end
        if (i_cmd.ld_nxt) begin
            r_nxt <= r_rdata;
        end
        if (i_cmd.start_walk) begin
            r_pos <= '0;
        end else if (i_cmd.step_pos) begin
            r_pos <= r_pos + span;
        end else if (i_cmd.jump_nxt) begin
            r_pos <= nx;
        end
        if (i_cmd.start_walk) begin
            r_total   <= '0;
            r_largest <= '0;
        end else if (i_cmd.acc_cur) begin
            r_total <= total_sum[16:15] != 2'b00 ? REPORT_MAX : total_sum[REPORT_W-1:0];
            if (pay > {1'b0, r_largest}) begin
                r_largest <= pay[15] ? REPORT_MAX : pay[REPORT_W-1:0];
            end
        end
        if (i_cmd.load_req) begin
            r_status  <= ST_OK;
            r_granted <= '0;
        end else if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end else if (i_cmd.wr_claim) begin
            r_granted <= r_pos[ADDR_W-1:0] + 12'd1;
        end
        if (i_cmd.out_load) begin
            r_out <= '{status: r_status, granted_offset: r_granted,
                       free_bytes: r_total, largest_free_bytes: r_largest};
        end
    end

    // Hold the pool size and the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_words <= POOL_MAX;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_pool_words <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import vbpa_pkg::*;

    // Action code with no effect on the pool
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int         NUM_SIZES = 7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_req              i_in_req;
    logic              o_out_valid;
    logic              i_out_stall;
    t_rsp              o_out_rsp;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;

    variable_block_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow pool: signed headers and the pool size in use
    int          shadow_hdr [HEAP_WORDS];
    int unsigned shadow_words;
    logic [11:0] live_offsets [$];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   errors;
    bit   req_taken;
    bit   idle_on;
    bit   long_hold_req;
    int   send_gap;
    int   stall_cnt;

    logic [SIZE_W-1:0] pool_settings [NUM_SIZES] =
        '{13'd0, 13'd2, 13'd8191, 13'd300, 13'd64, 13'd4096, 13'd3};

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned hdr_span(int h);
        if (h > 0) return h;
        if (h < 0) return -h;
        return 1;
    endfunction

    function automatic void pool_reform(logic [SIZE_W-1:0] words);
        shadow_words = pool_clamp(words);
        shadow_hdr[0] = shadow_words;
        live_offsets.delete();
    endfunction

    // Walk the pool, merging neighbours, and sum the free payload
    function automatic void free_space(output logic [REPORT_W-1:0] total,
                                       output logic [REPORT_W-1:0] largest);
        int unsigned pos;
        int unsigned nx;
        longint      tot;
        longint      lg;
        longint      pay;
        int          s;
        pos = 0;
        tot = 0;
        lg  = 0;
        while (pos < shadow_words) begin
            s = shadow_hdr[pos];
            if (s > 0) begin
                nx = pos + s;
                if (nx < shadow_words && shadow_hdr[nx] > 0) begin
                    shadow_hdr[pos] = s + shadow_hdr[nx];
                    continue;
                end
                pay = longint'(s - 1) * 8;
                tot += pay;
                if (pay > lg) lg = pay;
                pos = nx;
            end else begin
                pos += hdr_span(s);
            end
        end
        total   = (tot > 32767) ? REPORT_MAX : tot[REPORT_W-1:0];
        largest = (lg > 32767) ? REPORT_MAX : lg[REPORT_W-1:0];
    endfunction

    // First-fit allocation with merging on the way and a split at the end
    function automatic logic [1:0] pool_alloc(logic [14:0] bytes,
                                              output logic [11:0] granted);
        int unsigned need;
        int unsigned pos;
        int unsigned nx;
        int          s;
        need = (int'(bytes) + 7) / 8 + 1;
        pos = 0;
        granted = '0;
        while (pos < shadow_words) begin
            s = shadow_hdr[pos];
            if (s > 0) begin
                if (need <= s) begin
                    shadow_hdr[pos] = -int'(need);
                    if (need < s) shadow_hdr[pos + need] = s - need;
                    granted = 12'(pos + 1);
                    return ST_OK;
                end
                nx = pos + s;
                if (nx < shadow_words && shadow_hdr[nx] > 0) begin
                    shadow_hdr[pos] = s + shadow_hdr[nx];
                    continue;
                end
                pos = nx;
            end else begin
                pos += hdr_span(s);
            end
        end
        return ST_NOFIT;
    endfunction

    function automatic logic [1:0] pool_free(logic [11:0] offset);
        int unsigned target;
        int unsigned pos;
        if (offset == 0) return ST_NOTALLOC;
        target = offset - 1;
        if (target >= shadow_words) return ST_NOTALLOC;
        pos = 0;
        while (pos < shadow_words && pos < target) pos += hdr_span(shadow_hdr[pos]);
        if (pos != target || shadow_hdr[pos] >= 0) return ST_NOTALLOC;
        shadow_hdr[pos] = -shadow_hdr[pos];
        return ST_OK;
    endfunction

    // Work out the result of one request and update the shadow pool
    function automatic void predict_result(t_req r);
        t_rsp        rsp;
        logic [11:0] granted;
        rsp = '0;
        granted = '0;
        case (r.action)
            ACT_ALLOC: begin
                rsp.status = pool_alloc(r.request_bytes, granted);
                if (rsp.status == ST_OK) live_offsets.push_back(granted);
            end
            ACT_FREE: begin
                rsp.status = pool_free(r.payload_offset);
                if (rsp.status == ST_OK) begin
                    foreach (live_offsets[i]) begin
                        if (live_offsets[i] == r.payload_offset) begin
                            live_offsets.delete(i);
                            break;
                        end
                    end
                end
            end
            ACT_CLEAR: begin
                shadow_hdr[0] = shadow_words;
                live_offsets.delete();
            end
            default: ;
        endcase
        rsp.granted_offset = granted;
        free_space(rsp.free_bytes, rsp.largest_free_bytes);
        expected_rsps.push_back(rsp);
    endfunction

    // Note each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_result(i_in_req);
            req_taken = 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request driver: hold a stalled request, advance after acceptance
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_in_req   <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver stall, including one long hold-off on request
    always @(negedge i_clk) begin
        int r;
        if (stall_cnt > 0) begin
            stall_cnt--;
            i_out_stall <= 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_cnt = 300;
            i_out_stall <= 1'b1;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                stall_cnt = (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsps.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = expected_rsps.pop_front();
                if (o_out_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_rsp.status);
                    errors++;
                end
                if (o_out_rsp.granted_offset !== want.granted_offset) begin
                    $error("granted_offset: expected %0d, got %0d",
                           want.granted_offset, o_out_rsp.granted_offset);
                    errors++;
                end
                if (o_out_rsp.free_bytes !== want.free_bytes) begin
                    $error("free_bytes: expected %0d, got %0d",
                           want.free_bytes, o_out_rsp.free_bytes);
                    errors++;
                end
                if (o_out_rsp.largest_free_bytes !== want.largest_free_bytes) begin
                    $error("largest_free_bytes: expected %0d, got %0d",
                           want.largest_free_bytes, o_out_rsp.largest_free_bytes);
                    errors++;
                end
            end
        end
    end

    task automatic queue_req(logic [1:0] act, logic [14:0] bytes, logic [11:0] offset);
        t_req r;
        while (pending_reqs.size() >= 4) @(posedge i_clk);
        r.action = act;
        r.request_bytes = bytes;
        r.payload_offset = offset;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_pool_size(logic [SIZE_W-1:0] words);
        @(negedge i_clk);
        i_cfg_data  <= words;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        pool_reform(words);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random requests: mostly allocate and free of live blocks, some noise
    task automatic random_reqs(int count);
        int          r;
        int unsigned cap;
        logic [1:0]  act;
        logic [14:0] bytes;
        logic [11:0] offset;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            bytes  = 15'($urandom);
            offset = 12'($urandom);
            cap = shadow_words * 8;
            if (r < 55) begin
                act = ACT_ALLOC;
                r = $urandom_range(0, 99);
                if (r < 80) bytes = 15'($urandom_range(0, 120));
                else if (r < 95) bytes = 15'($urandom_range(0, cap));
            end else if (r < 95) begin
                act = ACT_FREE;
                r = $urandom_range(0, 99);
                if (live_offsets.size() > 0 && r < 85)
                    offset = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
                else if (live_offsets.size() > 0 && r < 92)
                    offset = live_offsets[0] + 12'd1;
            end else if (r < 98) begin
                act = ACT_CLEAR;
            end else begin
                act = ACT_NONE;
            end
            if (n == count / 3) long_hold_req = 1'b1;
            queue_req(act, bytes, offset);
        end
    endtask

    // Stimulus
    initial begin
        errors        = 0;
        req_taken     = 1'b0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        send_gap      = 0;
        stall_cnt     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_req      = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        foreach (shadow_hdr[i]) shadow_hdr[i] = 0;
        pool_reform(13'd4096);
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, every action, failure and bad-free cases
        queue_req(ACT_ALLOC, 15'd0, 12'd0);
        queue_req(ACT_ALLOC, 15'd1, 12'hFFF);
        queue_req(ACT_ALLOC, 15'd8, 12'd0);
        queue_req(ACT_ALLOC, 15'd9, 12'd0);
        queue_req(ACT_FREE, 15'h7FFF, 12'd1);
        queue_req(ACT_FREE, 15'd0, 12'd1);
        queue_req(ACT_FREE, 15'd0, 12'd0);
        queue_req(ACT_FREE, 15'd0, 12'd4);
        queue_req(ACT_FREE, 15'd0, 12'd4095);
        queue_req(ACT_ALLOC, 15'h7FFF, 12'd0);
        queue_req(ACT_ALLOC, 15'd16, 12'd0);
        queue_req(ACT_NONE, 15'h7FFF, 12'hFFF);
        queue_req(ACT_CLEAR, 15'h7FFF, 12'hFFF);
        queue_req(ACT_ALLOC, 15'd32760, 12'd0);
        queue_req(ACT_ALLOC, 15'd0, 12'd0);
        queue_req(ACT_FREE, 15'd0, 12'd1);
        queue_req(ACT_ALLOC, 15'd32752, 12'd0);
        queue_req(ACT_ALLOC, 15'd0, 12'd0);
        queue_req(ACT_ALLOC, 15'd0, 12'd0);
        queue_req(ACT_FREE, 15'd0, 12'd1);
        queue_req(ACT_FREE, 15'd0, 12'd4095);
        queue_req(ACT_CLEAR, 15'd0, 12'd0);
        random_reqs(150);
        wait_idle();

        // One phase per pool size, idling off in the phases where k mod 3 is 1
        for (int k = 0; k < NUM_SIZES; k++) begin
            idle_on = (k % 3) != 1;
            write_pool_size(pool_settings[k]);
            random_reqs(125);
            wait_idle();
        end

        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit
    initial begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/vbpa_pkg.sv
hdl/vbpa_ctrl.sv
hdl/vbpa_dp.sv
hdl/variable_block_pool_allocator.sv
bench/tb.sv
